// ----- rtl/rau_pkg.sv -----
`default_nettype none

package rau_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int DEN_W         = OPERAND_WIDTH - 1;
   localparam int FUNC_W        = 3;
   localparam int RES_NUM_W     = 32;
   localparam int RES_DEN_W     = 30;
   localparam int PROD_W        = 2 * OPERAND_WIDTH;
   localparam int DPROD_W       = 2 * DEN_W;
   localparam int CNT_W         = $clog2(OPERAND_WIDTH);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [FUNC_W-1:0] FUNC_ADD = FUNC_W'(0);
   localparam logic [FUNC_W-1:0] FUNC_SUB = FUNC_W'(1);
   localparam logic [FUNC_W-1:0] FUNC_MUL = FUNC_W'(2);
   localparam logic [FUNC_W-1:0] FUNC_INC = FUNC_W'(3);
   localparam logic [FUNC_W-1:0] FUNC_DEC = FUNC_W'(4);
   localparam logic [FUNC_W-1:0] FUNC_RED = FUNC_W'(5);

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_INC,
      OP_DEC,
      OP_RED,
      OP_PASS
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [OPERAND_WIDTH-1:0]  a_num;
      logic [DEN_W-1:0]          a_den;
      logic [OPERAND_WIDTH-1:0]  b_num;
      logic [DEN_W-1:0]          b_den;
      logic                      a_neg;
      logic [OPERAND_WIDTH-1:0]  a_mag;
   } job_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QCNT_W-1:0] count;
   } q_status_type;

endpackage

`default_nettype wire

// ----- rtl/rau_if.sv -----
`default_nettype none

interface rau_req_if;
   import rau_pkg::*;

   logic                             valid;
   logic                             ready;
   logic [FUNC_W-1:0]                func;
   logic signed [OPERAND_WIDTH-1:0]  a_num;
   logic [DEN_W-1:0]                 a_den;
   logic signed [OPERAND_WIDTH-1:0]  b_num;
   logic [DEN_W-1:0]                 b_den;

   modport source (output valid, output func, output a_num, output a_den,
                   output b_num, output b_den, input ready);
   modport sink (input valid, input func, input a_num, input a_den,
                 input b_num, input b_den, output ready);
endinterface

interface rau_rsp_if;
   import rau_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [RES_NUM_W-1:0]  res_num;
   logic [RES_DEN_W-1:0]         res_den;

   modport source (output valid, output res_num, output res_den, input ready);
   modport sink (input valid, input res_num, input res_den, output ready);
endinterface

`default_nettype wire

// ----- rtl/rau_front.sv -----
`default_nettype none

module rau_front (
   rau_req_if.sink                 req_ch,
   input  rau_pkg::q_status_type   q_stat,
   output logic                    push_valid,
   output rau_pkg::job_type        push_data
);
   import rau_pkg::*;

   assign req_ch.ready = !q_stat.full;
   assign push_valid   = req_ch.valid;

   always_comb begin
      push_data.a_num = req_ch.a_num;
      push_data.a_den = req_ch.a_den;
      push_data.b_num = req_ch.b_num;
      push_data.b_den = req_ch.b_den;
      push_data.a_neg = req_ch.a_num[OPERAND_WIDTH-1];
      // -(-2^(w-1)) wraps to 2^(w-1), which is the right unsigned magnitude
      push_data.a_mag = push_data.a_neg ? (OPERAND_WIDTH'(0) - req_ch.a_num)
                                        : req_ch.a_num;
      unique case (req_ch.func)
         FUNC_ADD: push_data.op = OP_ADD;
         FUNC_SUB: push_data.op = OP_SUB;
         FUNC_MUL: push_data.op = OP_MUL;
         FUNC_INC: push_data.op = OP_INC;
         FUNC_DEC: push_data.op = OP_DEC;
         // zero numerator reduces to itself
         FUNC_RED: push_data.op = (req_ch.a_num == '0) ? OP_PASS : OP_RED;
         default:  push_data.op = OP_PASS;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/rau_queue.sv -----
`default_nettype none

module rau_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  rau_pkg::job_type        push_data,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output rau_pkg::job_type        pop_data,
   output rau_pkg::q_status_type   q_stat
);
   import rau_pkg::*;

   job_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic                  push, pop;

   assign q_stat.count = count_ff;
   assign q_stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

   assign pop_valid = !q_stat.empty;
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign push      = push_valid && !q_stat.full;
   assign pop       = pop_ready && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/rau_back.sv -----
`default_nettype none

module rau_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  rau_pkg::job_type   pop_data,
   rau_rsp_if.source          rsp_ch
);
   import rau_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_MUL    = 6'b000010,
      ST_GCD    = 6'b000100,
      ST_DIV    = 6'b001000,
      ST_RESULT = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type                    state_ff, state_in;
   job_type                      job_ff, job_in;
   logic signed [PROD_W-1:0]     p0_ff, p0_in;
   logic signed [PROD_W-1:0]     p1_ff, p1_in;
   logic [DPROD_W-1:0]           p2_ff, p2_in;
   logic [OPERAND_WIDTH-1:0]     gx_ff, gx_in;
   logic [OPERAND_WIDTH-1:0]     gy_ff, gy_in;
   logic [CNT_W-1:0]             gk_ff, gk_in;
   logic [OPERAND_WIDTH-1:0]     g_ff, g_in;
   logic [OPERAND_WIDTH-1:0]     qa_ff, qa_in;
   logic [OPERAND_WIDTH-1:0]     qd_ff, qd_in;
   logic [OPERAND_WIDTH-1:0]     ra_ff, ra_in;
   logic [OPERAND_WIDTH-1:0]     rd_ff, rd_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [RES_NUM_W-1:0]         num_ff, num_in;
   logic [RES_DEN_W-1:0]         den_ff, den_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [RES_NUM_W-1:0]         rsp_num_ff, rsp_num_in;
   logic [RES_DEN_W-1:0]         rsp_den_ff, rsp_den_in;

   logic [OPERAND_WIDTH-1:0]     mul_b;
   logic [OPERAND_WIDTH:0]       ra_sh, rd_sh;
   logic [RES_NUM_W-1:0]         an_w, ad_w, mag_w;
   logic                         out_free;

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.res_num = rsp_num_ff;
   assign rsp_ch.res_den = rsp_den_ff;
   assign pop_ready      = (state_ff == ST_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_ch.ready;

   // shared multiplier operands
   assign mul_b = (job_ff.op == OP_MUL) ? job_ff.b_num : {1'b0, job_ff.b_den};
   assign p0_in = $signed(job_ff.a_num) * $signed(mul_b);
   assign p1_in = $signed(job_ff.b_num) * $signed({1'b0, job_ff.a_den});
   assign p2_in = job_ff.a_den * job_ff.b_den;

   // restoring divide step, both dividends against the same gcd
   assign ra_sh = {ra_ff, qa_ff[OPERAND_WIDTH-1]};
   assign rd_sh = {rd_ff, qd_ff[OPERAND_WIDTH-1]};

   assign an_w  = RES_NUM_W'($signed(job_ff.a_num));
   assign ad_w  = RES_NUM_W'(job_ff.a_den);
   assign mag_w = RES_NUM_W'(qa_ff);

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      gk_in        = gk_ff;
      g_in         = g_ff;
      qa_in        = qa_ff;
      qd_in        = qd_ff;
      ra_in        = ra_ff;
      rd_in        = rd_ff;
      cnt_in       = cnt_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               job_in = pop_data;
               gx_in  = pop_data.a_mag;
               gy_in  = {1'b0, pop_data.a_den};
               gk_in  = '0;
               state_in = (pop_data.op == OP_RED) ? ST_GCD : ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_RESULT;
         end
         ST_GCD: begin
            // binary gcd; ends when one side reaches zero
            if (gx_ff == '0 || gy_ff == '0) begin
               g_in     = (gx_ff | gy_ff) << gk_ff;
               qa_in    = job_ff.a_mag;
               qd_in    = {1'b0, job_ff.a_den};
               ra_in    = '0;
               rd_in    = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end else begin
               case ({gx_ff[0], gy_ff[0]})
                  2'b00: begin
                     gx_in = gx_ff >> 1;
                     gy_in = gy_ff >> 1;
                     gk_in = gk_ff + 1'b1;
                  end
                  2'b01: gx_in = gx_ff >> 1;
                  2'b10: gy_in = gy_ff >> 1;
                  default: begin
                     if (gx_ff >= gy_ff) begin
                        gx_in = gx_ff - gy_ff;
                     end else begin
                        gy_in = gy_ff - gx_ff;
                     end
                  end
               endcase
            end
         end
         ST_DIV: begin
            // remainder stays below the gcd, so it fits OPERAND_WIDTH bits
            if (ra_sh >= {1'b0, g_ff}) begin
               ra_in = OPERAND_WIDTH'(ra_sh - {1'b0, g_ff});
               qa_in = {qa_ff[OPERAND_WIDTH-2:0], 1'b1};
            end else begin
               ra_in = ra_sh[OPERAND_WIDTH-1:0];
               qa_in = {qa_ff[OPERAND_WIDTH-2:0], 1'b0};
            end
            if (rd_sh >= {1'b0, g_ff}) begin
               rd_in = OPERAND_WIDTH'(rd_sh - {1'b0, g_ff});
               qd_in = {qd_ff[OPERAND_WIDTH-2:0], 1'b1};
            end else begin
               rd_in = rd_sh[OPERAND_WIDTH-1:0];
               qd_in = {qd_ff[OPERAND_WIDTH-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(OPERAND_WIDTH - 1)) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            unique case (job_ff.op)
               OP_ADD: begin
                  num_in = RES_NUM_W'(p0_ff) + RES_NUM_W'(p1_ff);
                  den_in = RES_DEN_W'(p2_ff);
               end
               OP_SUB: begin
                  num_in = RES_NUM_W'(p0_ff) - RES_NUM_W'(p1_ff);
                  den_in = RES_DEN_W'(p2_ff);
               end
               OP_MUL: begin
                  num_in = RES_NUM_W'(p0_ff);
                  den_in = RES_DEN_W'(p2_ff);
               end
               OP_INC: begin
                  num_in = an_w + ad_w;
                  den_in = RES_DEN_W'(job_ff.a_den);
               end
               OP_DEC: begin
                  num_in = an_w - ad_w;
                  den_in = RES_DEN_W'(job_ff.a_den);
               end
               OP_RED: begin
                  num_in = job_ff.a_neg ? (RES_NUM_W'(0) - mag_w) : mag_w;
                  den_in = RES_DEN_W'(qd_ff);
               end
               default: begin
                  num_in = an_w;
                  den_in = RES_DEN_W'(job_ff.a_den);
               end
            endcase
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = num_ff;
               rsp_den_in   = den_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff     <= job_in;
      p0_ff      <= p0_in;
      p1_ff      <= p1_in;
      p2_ff      <= p2_in;
      gx_ff      <= gx_in;
      gy_ff      <= gy_in;
      gk_ff      <= gk_in;
      g_ff       <= g_in;
      qa_ff      <= qa_in;
      qd_ff      <= qd_in;
      ra_ff      <= ra_in;
      rd_ff      <= rd_in;
      cnt_ff     <= cnt_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
   end

endmodule

`default_nettype wire

// ----- rtl/rational_arithmetic_unit.sv -----
`default_nettype none

// Channel   Dir  Handshake          Payload
// req_ch    in   valid/ready        func, a_num, a_den, b_num, b_den
// rsp_ch    out  valid/ready        res_num, res_den
//
// Add, subtract, multiply, increment, decrement and pass-through go from the
// queue head through ST_MUL, ST_RESULT and ST_DONE to the response register.
// Reduce runs the binary gcd loop (one step a cycle), then OPERAND_WIDTH
// restoring divide steps, then ST_RESULT and ST_DONE.
// Reset clears the queue, the back-end state machine and the response valid.
// The front takes requests while the two-entry queue has room; a stalled
// response holds only the back end, which still finishes its current request.

module rational_arithmetic_unit (
   input  wire          clock,
   input  wire          reset,
   rau_req_if.sink      req_ch,
   rau_rsp_if.source    rsp_ch
);
   import rau_pkg::*;

   logic           fr_push_valid;
   job_type        fr_push_data;
   logic           q_pop_valid;
   job_type        q_pop_data;
   logic           bk_pop_ready;
   q_status_type   q_stat;

   rau_front u_front (
      .req_ch     (req_ch),
      .q_stat     (q_stat),
      .push_valid (fr_push_valid),
      .push_data  (fr_push_data)
   );

   rau_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_push_valid),
      .push_data  (fr_push_data),
      .pop_valid  (q_pop_valid),
      .pop_ready  (bk_pop_ready),
      .pop_data   (q_pop_data),
      .q_stat     (q_stat)
   );

   rau_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (q_pop_valid),
      .pop_ready  (bk_pop_ready),
      .pop_data   (q_pop_data),
      .rsp_ch     (rsp_ch)
   );

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |-> !q_stat.full)
      else $error("request accepted while queue full");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (QCNT_W + 1)'(q_stat.count) ==
               (QCNT_W + 1)'($past(q_stat.count))
               + (QCNT_W + 1)'($past(req_ch.valid && req_ch.ready))
               - (QCNT_W + 1)'($past(bk_pop_ready && q_pop_valid)))
      else $error("queue count does not match push/pop history");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      q_pop_valid == !q_stat.empty && q_stat.empty == (q_stat.count == '0))
      else $error("queue empty flag inconsistent");
`endif

endmodule

`default_nettype wire
